### rtl/core/dkc_pkg.sv
// ----------------------------------------------------------------------------
// dkc_pkg
// shared types and codes of the keypad calculator
// ----------------------------------------------------------------------------
package dkc_pkg;

  localparam logic [1:0] OPC_DIGIT  = 2'd0;
  localparam logic [1:0] OPC_OP     = 2'd1;
  localparam logic [1:0] OPC_CANCEL = 2'd2;
  localparam logic [1:0] OPC_RESET  = 2'd3;

  localparam logic [2:0] KEY_ADD   = 3'd0;
  localparam logic [2:0] KEY_SUB   = 3'd1;
  localparam logic [2:0] KEY_MUL   = 3'd2;
  localparam logic [2:0] KEY_DIV   = 3'd3;
  localparam logic [2:0] KEY_EQUAL = 3'd4;
  localparam logic [2:0] NONE_PENDING = 3'd4;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DIGIT = 2'd1;
  localparam logic [1:0] ACT_MINUS = 2'd2;
  localparam logic [1:0] ACT_ERROR = 2'd3;

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_DIGIT  = 3'd0,
    CMD_OPKEY  = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_RESET  = 3'd3,
    CMD_EQUAL  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] digit;
    logic [2:0] key;
  } cmd_t;

endpackage

### rtl/core/dkc_front.sv
// ----------------------------------------------------------------------------
// dkc_front
// accepts keypad events, drops meaningless ones, queues classified commands
// ----------------------------------------------------------------------------
module dkc_front import dkc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [3:0] digit_value,
  input  logic [2:0] op_key,
  output logic       cmd_valid,
  input  logic       cmd_take,
  output cmd_t       cmd
);

  // two-entry queue
  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop, keep;
  cmd_t       cls;

  always_comb begin
    cls.kind  = CMD_DIGIT;
    cls.digit = digit_value;
    cls.key   = op_key;
    keep      = 1'b1;
    unique case (opcode)
      OPC_DIGIT: begin
        cls.kind = CMD_DIGIT;
        keep     = (digit_value <= MAX_DIGIT);
      end
      OPC_OP: begin
        cls.kind = (op_key == KEY_EQUAL) ? CMD_EQUAL : CMD_OPKEY;
        keep     = (op_key <= KEY_EQUAL);
      end
      OPC_CANCEL: cls.kind = CMD_CANCEL;
      OPC_RESET:  cls.kind = CMD_RESET;
      default:    keep = 1'b0;
    endcase
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/dkc_back.sv
// ----------------------------------------------------------------------------
// dkc_back
// executes commands: operand entry, arithmetic, serial divide, decimal output
// ----------------------------------------------------------------------------
module dkc_back import dkc_pkg::*; #(
  parameter int W = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_take,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] display_action,
  output logic [3:0] shown_digit,
  output logic       last
);

  localparam int CW  = $clog2(W + 1);
  localparam int ND  = (W * 30103) / 100000 + 2; // digits of 2^(W-1), plus slack
  localparam int DW  = $clog2(ND + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EMIT  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_FIX   = 9'b000010000,
    S_CONV  = 9'b000100000,
    S_CDIV  = 9'b001000000,
    S_SIGN  = 9'b010000000,
    S_DIGS  = 9'b100000000
  } state_t;

  state_t state;

  logic [W-1:0] first_value, second_value;
  logic [2:0]   pending_op;

  // shift/subtract divider: divides num by den one bit a cycle
  logic [W-1:0] num, quo;
  logic [W-1:0] den;
  logic [W:0]   rem;
  logic [CW-1:0] bitcnt;
  logic         neg_res;

  // multiply by shift-add
  logic [W-1:0] acc, mcand, mplier;

  // decimal digits, built by shift-and-add-3
  logic [4*ND-1:0] bcd;
  logic [4*ND-1:0] bcd_adj;
  logic [DW-1:0] ndig;
  logic [DW-1:0] sig_cnt;
  logic [DW-1:0] top_idx;
  logic [W-1:0] conv;
  logic         neg_show;

  // output register
  logic [1:0]   act_r;
  logic [3:0]   dig_r;
  logic         last_r;
  logic         ovalid;
  logic         out_free;
  logic         out_load;

  logic [W:0]   rem_sh;

  assign out_valid      = ovalid;
  assign display_action = act_r;
  assign shown_digit    = dig_r;
  assign last           = last_r;
  assign cmd_take       = (state == S_IDLE) && !ovalid;

  assign rem_sh = {rem[W-1:0], num[W-1]};

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [4*ND-1:0] dd_adj(input logic [4*ND-1:0] v);
    dd_adj = v;
    for (int i = 0; i < ND; i++) begin
      if (v[4*i +: 4] >= 4'd5) dd_adj[4*i +: 4] = v[4*i +: 4] + 4'd3;
    end
  endfunction

  assign bcd_adj = dd_adj(bcd);
  assign top_idx = ndig - 1'b1;

  // number of significant decimal digits, at least one
  always_comb begin
    sig_cnt = DW'(1);
    for (int i = 1; i < ND; i++) begin
      if (bcd[4*i +: 4] != 4'd0) sig_cnt = DW'(i + 1);
    end
  end

  assign out_free = !ovalid || !out_stall;
  assign out_load = (state == S_IDLE && cmd_valid && !ovalid && cmd.kind != CMD_RESET) ||
                    (state == S_EMIT && out_free) ||
                    (state == S_SIGN && out_free && neg_show) ||
                    (state == S_DIGS && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (!out_stall) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_value  <= '0;
      second_value <= '0;
      pending_op   <= NONE_PENDING;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && !ovalid) begin
            unique case (cmd.kind)
              CMD_DIGIT: begin
                if (pending_op == NONE_PENDING)
                  first_value <= (first_value << 3) + (first_value << 1) + W'(cmd.digit);
                else
                  second_value <= (second_value << 3) + (second_value << 1) + W'(cmd.digit);
                act_r <= ACT_DIGIT; dig_r <= cmd.digit; last_r <= 1'b1;
              end
              CMD_CANCEL: begin
                if (pending_op == NONE_PENDING) first_value <= '0;
                else second_value <= '0;
                act_r <= ACT_CLEAR; dig_r <= '0; last_r <= 1'b1;
              end
              CMD_RESET: begin
                first_value  <= '0;
                second_value <= '0;
                pending_op   <= NONE_PENDING;
              end
              CMD_OPKEY: begin
                pending_op <= cmd.key;
                act_r <= ACT_CLEAR; dig_r <= '0; last_r <= 1'b1;
              end
              CMD_EQUAL: begin
                act_r <= ACT_CLEAR; dig_r <= '0; last_r <= 1'b0;
                if (pending_op == NONE_PENDING) begin
                  state <= S_EMIT;
                end else if (pending_op == KEY_DIV && second_value == '0) begin
                  second_value <= '0;
                  pending_op   <= NONE_PENDING;
                  state <= S_EMIT;
                end else begin
                  unique case (pending_op)
                    KEY_ADD: begin
                      conv <= first_value + second_value;
                      state <= S_FIX;
                    end
                    KEY_SUB: begin
                      conv <= first_value - second_value;
                      state <= S_FIX;
                    end
                    KEY_MUL: begin
                      acc <= '0; mcand <= first_value; mplier <= second_value;
                      bitcnt <= CW'(W);
                      state <= S_MUL;
                    end
                    default: begin
                      num <= mag(first_value); den <= mag(second_value);
                      rem <= '0; bitcnt <= CW'(W);
                      neg_res <= first_value[W-1] ^ second_value[W-1];
                      state <= S_DIV;
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          // error item after the clear has gone
          if (out_free) begin
            act_r <= ACT_ERROR; dig_r <= '0; last_r <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == CW'(1)) begin
            conv  <= mplier[0] ? acc + mcand : acc;
            state <= S_FIX;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[W-2:0], 1'b0};
          end
          num    <= num << 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == CW'(1)) state <= S_CONV;
        end
        S_CONV: begin
          conv  <= neg_res ? (~quo + 1'b1) : quo;
          state <= S_FIX;
        end
        S_FIX: begin
          // conv holds the result: store it, start decimal conversion
          first_value  <= conv;
          second_value <= '0;
          pending_op   <= NONE_PENDING;
          neg_show     <= conv[W-1];
          num    <= mag(conv);
          bcd    <= '0;
          bitcnt <= CW'(W);
          state  <= S_CDIV;
        end
        S_CDIV: begin
          // add 3 to every digit of five or more, then shift in the next bit
          bcd    <= {bcd_adj[4*ND-2:0], num[W-1]};
          num    <= num << 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == CW'(1)) state <= S_SIGN;
        end
        S_SIGN: begin
          if (out_free) begin
            if (neg_show) begin
              act_r <= ACT_MINUS; dig_r <= '0; last_r <= 1'b0;
              neg_show <= 1'b0;
            end
            if (!neg_show) begin
              ndig  <= sig_cnt;
              state <= S_DIGS;
            end
          end
        end
        S_DIGS: begin
          if (out_free) begin
            act_r  <= ACT_DIGIT;
            dig_r  <= bcd[{top_idx, 2'b00} +: 4];
            last_r <= (ndig == DW'(1));
            ndig   <= ndig - 1'b1;
            if (ndig == DW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/decimal_keypad_calculator.sv
// ----------------------------------------------------------------------------
// decimal_keypad_calculator
// four-function integer calculator driven by keypad events
// ----------------------------------------------------------------------------
// A front stage accepts keypad events, drops invalid ones and queues them two
// deep; the back stage executes one at a time. Digit, operation and cancel keys
// give one result each. Equal runs a bit-serial multiply or restoring divide,
// then a shift-and-add-3 decimal conversion, and emits the symbols, waiting while
// the output is stalled; add and subtract skip the first part. An equal with no
// operation pending, or a divide by zero, shows an error instead.
module decimal_keypad_calculator import dkc_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [3:0] digit_value,
  input  logic [2:0] op_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] display_action,
  output logic [3:0] shown_digit,
  output logic       last
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  dkc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .digit_value, .op_key,
    .cmd_valid, .cmd_take, .cmd
  );

  dkc_back #(.W(OPERAND_WIDTH)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .display_action, .shown_digit, .last
  );

`ifndef SYNTHESIS
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_action == ACT_DIGIT |-> shown_digit <= MAX_DIGIT)
    else $error("digit out of range");
  a_zero_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_action != ACT_DIGIT |-> shown_digit == 4'd0)
    else $error("nonzero digit field");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !out_valid)
    else $error("command taken while output busy");
`endif

endmodule

### tb/tb_decimal_keypad_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_keypad_calculator
// self-checking testbench of the keypad calculator
// ----------------------------------------------------------------------------
// Keypad events go in through the valid/stall channel. A behavioral model of
// the operands and pending operation predicts every display symbol, and a
// checker compares each output transfer against the oldest prediction. Both
// sides idle in random bursts; one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_decimal_keypad_calculator;
  import dkc_pkg::*;

  localparam int W = 32;

  typedef struct packed {
    logic [1:0] act;
    logic [3:0] dig;
    logic       lst;
  } symbol_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = OPC_DIGIT;
  logic [3:0] digit_value = '0;
  logic [2:0] op_key = KEY_ADD;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] display_action;
  logic [3:0] shown_digit;
  logic       last;

  symbol_t    display_queue[$];
  logic [W-1:0] calc_a, calc_b;
  logic [2:0] calc_op;
  int         errors = 0;
  bit         idle_on = 1'b1;
  int         hold_cycles = 0;

  always #1 clk = ~clk;

  decimal_keypad_calculator #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .digit_value(digit_value), .op_key(op_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .display_action(display_action), .shown_digit(shown_digit), .last(last)
  );

  function automatic symbol_t sym(logic [1:0] a, logic [3:0] d);
    sym.act = a;
    sym.dig = d;
    sym.lst = 1'b0;
  endfunction

  // predict the symbols of one keypad event and advance the model state
  task automatic predict_display(logic [1:0] opc, logic [3:0] dg, logic [2:0] ky);
    symbol_t s[$];
    logic [W-1:0] r, ma, mb, q, m;
    logic [3:0] ds[$];
    s = {};
    case (opc)
      OPC_DIGIT: begin
        if (dg <= MAX_DIGIT) begin
          if (calc_op == NONE_PENDING) calc_a = calc_a * 10 + dg;
          else calc_b = calc_b * 10 + dg;
          s.push_back(sym(ACT_DIGIT, dg));
        end
      end
      OPC_CANCEL: begin
        if (calc_op == NONE_PENDING) calc_a = '0;
        else calc_b = '0;
        s.push_back(sym(ACT_CLEAR, 4'd0));
      end
      OPC_RESET: begin
        calc_a = '0;
        calc_b = '0;
        calc_op = NONE_PENDING;
      end
      default: begin
        if (ky < KEY_EQUAL) begin
          calc_op = ky;
          s.push_back(sym(ACT_CLEAR, 4'd0));
        end else if (ky == KEY_EQUAL) begin
          s.push_back(sym(ACT_CLEAR, 4'd0));
          if (calc_op == NONE_PENDING) begin
            s.push_back(sym(ACT_ERROR, 4'd0));
          end else if (calc_op == KEY_DIV && calc_b == 0) begin
            calc_b = '0;
            calc_op = NONE_PENDING;
            s.push_back(sym(ACT_ERROR, 4'd0));
          end else begin
            case (calc_op)
              KEY_ADD: r = calc_a + calc_b;
              KEY_SUB: r = calc_a - calc_b;
              KEY_MUL: r = calc_a * calc_b;
              default: begin
                ma = calc_a[W-1] ? -calc_a : calc_a;
                mb = calc_b[W-1] ? -calc_b : calc_b;
                q = ma / mb;
                r = (calc_a[W-1] != calc_b[W-1]) ? -q : q;
              end
            endcase
            calc_a = r;
            calc_b = '0;
            calc_op = NONE_PENDING;
            if (r[W-1]) s.push_back(sym(ACT_MINUS, 4'd0));
            m = r[W-1] ? -r : r;
            ds = {};
            do begin
              ds.push_front(4'(m % 10));
              m = m / 10;
            end while (m != 0);
            foreach (ds[i]) s.push_back(sym(ACT_DIGIT, ds[i]));
          end
        end
      end
    endcase
    if (s.size() > 0) s[s.size()-1].lst = 1'b1;
    foreach (s[i]) display_queue.push_back(s[i]);
  endtask

  task automatic send_key(logic [1:0] opc, logic [3:0] dg, logic [2:0] ky);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= opc;
    digit_value <= dg;
    op_key <= ky;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_display(opc, dg, ky);
    @(negedge clk);
  endtask

  // stall driver: random bursts, or a long hold-off when requested
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
        @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        @(negedge clk);
      end
    end
  end

  // output checker
  always @(posedge clk) begin
    symbol_t e;
    if (!rst && out_valid && !out_stall) begin
      if (display_queue.size() == 0) begin
        $display("%0t: unexpected transfer act=%0d dig=%0d last=%0b",
                 $time, display_action, shown_digit, last);
        errors++;
      end else begin
        e = display_queue.pop_front();
        if (e.act !== display_action || e.dig !== shown_digit || e.lst !== last) begin
          $display("%0t: mismatch expected act=%0d dig=%0d last=%0b, got act=%0d dig=%0d last=%0b",
                   $time, e.act, e.dig, e.lst, display_action, shown_digit, last);
          errors++;
        end
      end
    end
  end

  task automatic enter_number(logic [W-1:0] v);
    logic [3:0] ds[$];
    do begin
      ds.push_front(4'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (ds[i]) send_key(OPC_DIGIT, ds[i], KEY_ADD);
  endtask

  task automatic test_directed();
    send_key(OPC_OP, 4'd0, KEY_EQUAL);        // equal with nothing pending
    enter_number(32'd2147483647);
    send_key(OPC_OP, 4'd0, KEY_ADD);
    send_key(OPC_DIGIT, 4'd1, KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);        // wraps to most negative
    send_key(OPC_OP, 4'd0, KEY_DIV);
    send_key(OPC_DIGIT, 4'd15, KEY_ADD);      // digit above nine ignored
    send_key(OPC_OP, 4'd0, 3'd7);             // unused op code ignored
    send_key(OPC_OP, 4'd0, KEY_EQUAL);        // divide by zero
    send_key(OPC_OP, 4'd0, KEY_SUB);
    send_key(OPC_DIGIT, 4'd9, KEY_ADD);
    send_key(OPC_CANCEL, 4'd0, KEY_ADD);
    send_key(OPC_DIGIT, 4'd1, KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);
    send_key(OPC_OP, 4'd0, KEY_MUL);
    send_key(OPC_DIGIT, 4'd0, KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);
    send_key(OPC_CANCEL, 4'd0, KEY_ADD);
    send_key(OPC_RESET, 4'd0, KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);
  endtask

  task automatic test_min_div_minus_one();
    send_key(OPC_RESET, 4'd0, KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_SUB);
    send_key(OPC_DIGIT, 4'd1, KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);        // -1 in first operand
    send_key(OPC_OP, 4'd0, KEY_MUL);
    enter_number(32'd2147483648);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);        // most negative value
    send_key(OPC_OP, 4'd0, KEY_DIV);
    enter_number(32'd4294967295);             // -1
    send_key(OPC_OP, 4'd0, KEY_EQUAL);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (6) send_key(OPC_DIGIT, 4'($urandom_range(0, 9)), KEY_ADD);
    send_key(OPC_OP, 4'd0, KEY_MUL);
    enter_number($urandom);
    send_key(OPC_OP, 4'd0, KEY_EQUAL);
  endtask

  task automatic test_random(int count);
    int k, nd, sel;
    k = 0;
    while (k < count) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        // well-formed expression with random operands
        nd = $urandom_range(1, 10);
        repeat (nd) send_key(OPC_DIGIT, 4'($urandom_range(0, 9)), 3'($urandom));
        send_key(OPC_OP, 4'($urandom), 3'($urandom_range(0, 3)));
        nd = $urandom_range(0, 10);
        repeat (nd) send_key(OPC_DIGIT, 4'($urandom_range(0, 9)), 3'($urandom));
        if ($urandom_range(0, 7) == 0) send_key(OPC_CANCEL, 4'($urandom), 3'($urandom));
        send_key(OPC_OP, 4'($urandom), KEY_EQUAL);
        k += 2 * nd + 3;
      end else begin
        send_key(2'($urandom), 4'($urandom), 3'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    calc_a = '0;
    calc_b = '0;
    calc_op = NONE_PENDING;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_min_div_minus_one();
    test_backpressure();
    test_random(330);
    idle_on = 1'b0;
    test_random(80);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (display_queue.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (500) @(posedge clk);
    if (errors == 0 && display_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/dkc_pkg.sv
rtl/core/dkc_front.sv
rtl/core/dkc_back.sv
rtl/core/decimal_keypad_calculator.sv
tb/tb_decimal_keypad_calculator.sv
